// ----- hw/rtl/lmp_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and helpers for the linemarker line parser.
package lmp_pkg;

   localparam int LINE_BITS_DEF = 32;
   localparam int FLAG_BITS_DEF = 32;
   localparam int RQ_DEPTH      = 4;

   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;

   typedef struct packed {
      logic        is_verdict;
      logic [7:0]  name_byte;
      logic        ok;
      logic [31:0] line_number;
      logic [31:0] flag_mask;
      logic        run_end;
   } result_type;

   typedef struct packed {
      logic [1:0] cnt;
      result_type first;
      result_type second;
   } push_type;

   function automatic logic is_space(input logic [7:0] c);
      logic r;
      r = (c == 8'h20) || (c == 8'h0C) || (c == 8'h0D) || (c == 8'h09) || (c == 8'h0B);
      return r;
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      logic r;
      r = (c >= CH_ZERO) && (c <= CH_NINE);
      return r;
   endfunction

endpackage

// ----- hw/rtl/linemarker_line_parser_top.sv -----
`timescale 1ns / 1ps
// Top level of the linemarker line parser: input register, parser, result queue.
//
// Takes one byte per cycle while req_stall is low and reports, for each text
// line, the unescaped file name bytes of a linemarker followed by one verdict
// record with the line number and flag mask. A byte waits in the input register
// until the result queue has room, is parsed there, and its results are written
// into the queue, from which they leave on the result port. Sustained rate is
// one byte per cycle while each byte causes at most one result and the queue
// has room; a name byte that also ends the line gives two results and takes two
// transfers on the single result port. The four-entry result queue lets the input
// keep moving while a result waits on rsp_stall.
module linemarker_line_parser_top #(
   parameter int LINE_BITS = lmp_pkg::LINE_BITS_DEF,
   parameter int FLAG_BITS = lmp_pkg::FLAG_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_char_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_is_verdict,
   output logic [7:0]  rsp_name_byte,
   output logic        rsp_ok,
   output logic [31:0] rsp_line_number,
   output logic [31:0] rsp_flag_mask,
   output logic        rsp_run_end
);

   logic                in_valid_ff, in_valid_in;
   logic [7:0]          in_char_ff, in_char_in;
   logic                in_last_ff, in_last_in;
   logic                room;
   logic                advance;
   logic                accept;
   lmp_pkg::push_type   push;
   lmp_pkg::result_type out_res;

   assign advance   = in_valid_ff && room;
   assign req_stall = in_valid_ff && !room;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_valid_in = accept ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      in_char_in  = accept ? req_char_byte : in_char_ff;
      in_last_in  = accept ? req_last_byte : in_last_ff;
   end

   always_ff @(posedge clock) begin
      in_char_ff <= in_char_in;
      in_last_ff <= in_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   lmp_parser #(
      .LINE_BITS (LINE_BITS),
      .FLAG_BITS (FLAG_BITS)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .char_byte (in_char_ff),
      .last_byte (in_last_ff),
      .push      (push)
   );

   lmp_result_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_res   (out_res)
   );

   assign rsp_is_verdict  = out_res.is_verdict;
   assign rsp_name_byte   = out_res.name_byte;
   assign rsp_ok          = out_res.ok;
   assign rsp_line_number = out_res.line_number;
   assign rsp_flag_mask   = out_res.flag_mask;
   assign rsp_run_end     = out_res.run_end;

endmodule

// ----- hw/rtl/lmp_parser.sv -----
`timescale 1ns / 1ps
// Linemarker parse state and per-byte next-state and result logic.
module lmp_parser #(
   parameter int LINE_BITS = lmp_pkg::LINE_BITS_DEF,
   parameter int FLAG_BITS = lmp_pkg::FLAG_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic [7:0]        char_byte,
   input  logic              last_byte,
   output lmp_pkg::push_type push
);

   localparam int FA = $clog2(FLAG_BITS + 1);
   localparam int FW = FA + 4;
   localparam int LW = LINE_BITS + 4;
   localparam logic [FW-1:0] FLAG_MAX_W = FW'(FLAG_BITS);
   localparam logic [FA-1:0] FLAG_MAX   = FA'(FLAG_BITS);

   localparam logic [3:0] PH_HASH        = 4'd0;
   localparam logic [3:0] PH_LINE_START  = 4'd1;
   localparam logic [3:0] PH_LINE_DIGITS = 4'd2;
   localparam logic [3:0] PH_NAME_START  = 4'd3;
   localparam logic [3:0] PH_NAME_BODY   = 4'd4;
   localparam logic [3:0] PH_NAME_ESC    = 4'd5;
   localparam logic [3:0] PH_FLAG_WAIT   = 4'd6;
   localparam logic [3:0] PH_FLAG_DIGITS = 4'd7;
   localparam logic [3:0] PH_FAIL        = 4'd8;

   logic [3:0]           phase_ff, phase_in;
   logic [LINE_BITS-1:0] line_ff, line_in;
   logic [FA-1:0]        flag_ff, flag_in;
   logic [FLAG_BITS-1:0] mask_ff, mask_in;

   logic [3:0]           ph;
   logic [LINE_BITS-1:0] ln;
   logic [FA-1:0]        fl;
   logic [FLAG_BITS-1:0] mk;
   logic [FLAG_BITS-1:0] mk_close;
   logic                 close_ok;
   logic                 name_hit;
   logic                 eol;
   logic                 ok_v;
   logic [3:0]           dig;
   logic [LW-1:0]        line_x;
   logic [FW-1:0]        flag_x;
   logic [63:0]          line_wide;
   logic [63:0]          mask_wide;
   lmp_pkg::result_type  name_res;
   lmp_pkg::result_type  verd_res;

   assign dig    = char_byte[3:0];
   assign line_x = ({4'b0, line_ff} << 3) + ({4'b0, line_ff} << 1)
                 + {{LINE_BITS{1'b0}}, dig};
   assign flag_x = ({4'b0, flag_ff} << 3) + ({4'b0, flag_ff} << 1) + {{FA{1'b0}}, dig};
   assign eol    = last_byte || (char_byte == lmp_pkg::CH_NL);

   always_comb begin
      ph       = phase_ff;
      ln       = line_ff;
      fl       = flag_ff;
      mk       = mask_ff;
      name_hit = 1'b0;
      if (char_byte != lmp_pkg::CH_NL) begin
         case (phase_ff)
            PH_HASH: begin
               if (!lmp_pkg::is_space(char_byte))
                  ph = (char_byte == lmp_pkg::CH_HASH) ? PH_LINE_START : PH_FAIL;
            end
            PH_LINE_START, PH_LINE_DIGITS: begin
               if (lmp_pkg::is_space(char_byte)) begin
                  if (phase_ff == PH_LINE_DIGITS)
                     ph = PH_NAME_START;
               end else if (lmp_pkg::is_digit(char_byte)) begin
                  if (line_x[LW-1:LINE_BITS] != 4'b0) begin
                     ph = PH_FAIL;
                  end else begin
                     ln = line_x[LINE_BITS-1:0];
                     ph = PH_LINE_DIGITS;
                  end
               end else begin
                  ph = PH_FAIL;
               end
            end
            PH_NAME_START: begin
               if (!lmp_pkg::is_space(char_byte))
                  ph = (char_byte == lmp_pkg::CH_QUOTE) ? PH_NAME_BODY : PH_FAIL;
            end
            PH_NAME_BODY: begin
               if (char_byte == lmp_pkg::CH_QUOTE)
                  ph = PH_FLAG_WAIT;
               else if (char_byte == lmp_pkg::CH_BSLASH)
                  ph = PH_NAME_ESC;
               else
                  name_hit = 1'b1;
            end
            PH_NAME_ESC: begin
               name_hit = 1'b1;
               ph       = PH_NAME_BODY;
            end
            PH_FLAG_WAIT, PH_FLAG_DIGITS: begin
               if (lmp_pkg::is_space(char_byte)) begin
                  if (phase_ff == PH_FLAG_DIGITS) begin
                     if (flag_ff != '0 && flag_ff <= FLAG_MAX) begin
                        mk = mask_ff | (FLAG_BITS'(1) << (flag_ff - FA'(1)));
                        fl = '0;
                        ph = PH_FLAG_WAIT;
                     end else begin
                        ph = PH_FAIL;
                     end
                  end
               end else if (lmp_pkg::is_digit(char_byte)) begin
                  if (flag_x > FLAG_MAX_W) begin
                     ph = PH_FAIL;
                  end else begin
                     fl = flag_x[FA-1:0];
                     ph = PH_FLAG_DIGITS;
                  end
               end else begin
                  ph = PH_FAIL;
               end
            end
            default: ph = PH_FAIL;
         endcase
      end
   end

   // end-of-line flag close and verdict
   always_comb begin
      close_ok = (fl != '0) && (fl <= FLAG_MAX);
      mk_close = mk | (FLAG_BITS'(1) << (fl - FA'(1)));
      ok_v     = 1'b0;
      if (ph == PH_FLAG_WAIT)
         ok_v = 1'b1;
      else if (ph == PH_FLAG_DIGITS)
         ok_v = close_ok;
      line_wide = 64'(ln);
      mask_wide = (ph == PH_FLAG_DIGITS) ? 64'(mk_close) : 64'(mk);
   end

   always_comb begin
      name_res             = '0;
      name_res.is_verdict  = 1'b0;
      name_res.name_byte   = char_byte;
      name_res.run_end     = !eol;
      verd_res             = '0;
      verd_res.is_verdict  = 1'b1;
      verd_res.ok          = ok_v;
      verd_res.line_number = ok_v ? line_wide[31:0] : 32'd0;
      verd_res.flag_mask   = ok_v ? mask_wide[31:0] : 32'd0;
      verd_res.run_end     = 1'b1;
      push.cnt             = advance ? ({1'b0, name_hit} + {1'b0, eol}) : 2'd0;
      push.first           = name_hit ? name_res : verd_res;
      push.second          = verd_res;
   end

   always_comb begin
      phase_in = phase_ff;
      line_in  = line_ff;
      flag_in  = flag_ff;
      mask_in  = mask_ff;
      if (advance) begin
         if (eol) begin
            phase_in = PH_HASH;
            line_in  = '0;
            flag_in  = '0;
            mask_in  = '0;
         end else begin
            phase_in = ph;
            line_in  = ln;
            flag_in  = fl;
            mask_in  = mk;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HASH;
         line_ff  <= '0;
         flag_ff  <= '0;
         mask_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         line_ff  <= line_in;
         flag_ff  <= flag_in;
         mask_ff  <= mask_in;
      end
   end

   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      push.cnt == 2'd2 |-> !push.first.is_verdict && push.second.is_verdict)
      else $error("two results must be name byte then verdict");

   a_clear_after_eol: assert property (@(posedge clock) disable iff (reset)
      advance && eol |=> phase_ff == PH_HASH && line_ff == '0 && mask_ff == '0)
      else $error("parse state not cleared after end of line");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      push.cnt != 2'd0 && push.second.is_verdict && !push.second.ok
      |-> push.second.line_number == 32'd0 && push.second.flag_mask == 32'd0)
      else $error("failing verdict carries nonzero fields");

endmodule

// ----- hw/rtl/lmp_result_queue.sv -----
`timescale 1ns / 1ps
// Result queue: takes up to two results per cycle, hands out one per transfer.
module lmp_result_queue (
   input  logic                clock,
   input  logic                reset,
   input  lmp_pkg::push_type   push,
   output logic                room,
   output logic                out_valid,
   input  logic                out_stall,
   output lmp_pkg::result_type out_res
);

   localparam int QA = $clog2(lmp_pkg::RQ_DEPTH);
   localparam int CW = QA + 1;
   localparam logic [CW-1:0] ROOM_MAX = CW'(lmp_pkg::RQ_DEPTH - 2);
   localparam logic [CW-1:0] DEPTH_C  = CW'(lmp_pkg::RQ_DEPTH);

   lmp_pkg::result_type entries_ff [lmp_pkg::RQ_DEPTH];
   logic [QA-1:0] head_ff, head_in;
   logic [QA-1:0] tail_ff, tail_in;
   logic [CW-1:0] count_ff, count_in;
   logic          pop;

   assign room      = count_ff <= ROOM_MAX;
   assign out_valid = count_ff != '0;
   assign out_res   = entries_ff[head_ff];
   assign pop       = out_valid && !out_stall;

   always_comb begin
      head_in  = pop ? head_ff + QA'(1) : head_ff;
      tail_in  = tail_ff + QA'(push.cnt);
      count_in = count_ff + CW'(push.cnt) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.cnt != 2'd0)
         entries_ff[tail_ff] <= push.first;
      if (push.cnt == 2'd2)
         entries_ff[tail_ff + QA'(1)] <= push.second;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push.cnt != 2'd0 |-> room)
      else $error("results written without room");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_C)
      else $error("queue count beyond depth");

   a_ptr_track: assert property (@(posedge clock) disable iff (reset)
      tail_ff == head_ff + count_ff[QA-1:0])
      else $error("queue pointers and count disagree");

endmodule

// ----- dv/linemarker_line_parser_top_test.sv -----
`timescale 1ns / 1ps
// Testbench for linemarker_line_parser_top: directed and random text lines checked by a parser model.
module linemarker_line_parser_top_test;

   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_FF    = 8'h0C;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_VT    = 8'h0B;
   localparam longint unsigned LINE_MAX = (64'd1 << lmp_pkg::LINE_BITS_DEF) - 64'd1;
   localparam int RANDOM_BYTES = 1700;
   localparam int CYCLE_LIMIT  = 400000;

   typedef enum logic [3:0] {
      AWAIT_HASH, LINE_LEAD, LINE_NUM, NAME_LEAD, NAME_TEXT, NAME_ESCAPE,
      FLAG_GAP, FLAG_NUM, REJECT
   } marker_phase_type;

   typedef struct {
      logic [7:0]          ch;
      logic                last;
      bit                  typed;
      lmp_pkg::result_type verdict;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_char_byte = 8'h00;
   logic        req_last_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_is_verdict;
   logic [7:0]  rsp_name_byte;
   logic        rsp_ok;
   logic [31:0] rsp_line_number;
   logic [31:0] rsp_flag_mask;
   logic        rsp_run_end;

   bit calm = 1'b0;
   bit hold_go = 1'b0;
   bit hold_done = 1'b0;
   int hold_cycles = 0;
   int cycle_count = 0;
   int failures = 0;

   marker_phase_type phase = AWAIT_HASH;
   longint unsigned  line_acc = 0;
   int unsigned      flag_acc = 0;
   longint unsigned  mask_acc = 0;

   lmp_pkg::result_type expected_results [$];
   stim_row_type        directed_rows [$];
   logic [7:0]          line_text [$];
   bit                  end_on_last;

   linemarker_line_parser_top DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_char_byte(req_char_byte),
      .req_last_byte(req_last_byte),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_is_verdict(rsp_is_verdict),
      .rsp_name_byte(rsp_name_byte),
      .rsp_ok(rsp_ok),
      .rsp_line_number(rsp_line_number),
      .rsp_flag_mask(rsp_flag_mask),
      .rsp_run_end(rsp_run_end)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic bit close_flag();
      if (flag_acc < 1 || flag_acc > lmp_pkg::FLAG_BITS_DEF) return 1'b0;
      mask_acc = mask_acc | (64'd1 << (flag_acc - 1));
      flag_acc = 0;
      return 1'b1;
   endfunction

   function automatic lmp_pkg::result_type verdict(input logic ok, input logic [31:0] num,
                                                   input logic [31:0] mask);
      lmp_pkg::result_type r;
      r = '0;
      r.is_verdict = 1'b1;
      r.ok = ok;
      r.line_number = num;
      r.flag_mask = mask;
      r.run_end = 1'b1;
      return r;
   endfunction

   task automatic predict_byte(input logic [7:0] c, input logic last);
      lmp_pkg::result_type produced [$];
      lmp_pkg::result_type r;
      longint unsigned digit;
      int unsigned flag_next;
      bit blank, numeral, good;
      blank = c inside {CH_SPACE, CH_FF, CH_CR, CH_TAB, CH_VT};
      numeral = c >= lmp_pkg::CH_ZERO && c <= lmp_pkg::CH_NINE;
      digit = c - lmp_pkg::CH_ZERO;
      r = '0;
      if (c != lmp_pkg::CH_NL) begin
         case (phase)
            AWAIT_HASH: begin
               if (!blank) phase = (c == lmp_pkg::CH_HASH) ? LINE_LEAD : REJECT;
            end
            LINE_LEAD, LINE_NUM: begin
               if (blank) begin
                  if (phase == LINE_NUM) phase = NAME_LEAD;
               end else if (numeral) begin
                  if (line_acc > (LINE_MAX - digit) / 10) begin
                     phase = REJECT;
                  end else begin
                     line_acc = line_acc * 10 + digit;
                     phase = LINE_NUM;
                  end
               end else begin
                  phase = REJECT;
               end
            end
            NAME_LEAD: begin
               if (!blank) phase = (c == lmp_pkg::CH_QUOTE) ? NAME_TEXT : REJECT;
            end
            NAME_TEXT: begin
               if (c == lmp_pkg::CH_QUOTE) begin
                  phase = FLAG_GAP;
               end else if (c == lmp_pkg::CH_BSLASH) begin
                  phase = NAME_ESCAPE;
               end else begin
                  r.name_byte = c;
                  produced.push_back(r);
               end
            end
            NAME_ESCAPE: begin
               r.name_byte = c;
               produced.push_back(r);
               phase = NAME_TEXT;
            end
            FLAG_GAP, FLAG_NUM: begin
               if (blank) begin
                  if (phase == FLAG_NUM) phase = close_flag() ? FLAG_GAP : REJECT;
               end else if (numeral) begin
                  flag_next = flag_acc * 10 + digit;
                  if (flag_next > lmp_pkg::FLAG_BITS_DEF) begin
                     phase = REJECT;
                  end else begin
                     flag_acc = flag_next;
                     phase = FLAG_NUM;
                  end
               end else begin
                  phase = REJECT;
               end
            end
            default: phase = REJECT;
         endcase
      end
      if (last || c == lmp_pkg::CH_NL) begin
         if (phase == FLAG_GAP) good = 1'b1;
         else if (phase == FLAG_NUM) good = close_flag();
         else good = 1'b0;
         if (good) produced.push_back(verdict(1'b1, line_acc[31:0], mask_acc[31:0]));
         else produced.push_back(verdict(1'b0, 32'd0, 32'd0));
         phase = AWAIT_HASH;
         line_acc = 0;
         flag_acc = 0;
         mask_acc = 0;
      end
      if (produced.size() != 0) begin
         r = produced.pop_back();
         r.run_end = 1'b1;
         produced.push_back(r);
      end
      foreach (produced[i]) expected_results.push_back(produced[i]);
   endtask

   task automatic send_byte(input logic [7:0] c, input logic last);
      while (!calm && $urandom_range(0, 99) < 18) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_char_byte <= c;
      req_last_byte <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_byte(c, last);
   endtask

   task automatic add_row(input logic [7:0] c, input logic last, input bit typed,
                          input logic ok, input logic [31:0] num, input logic [31:0] mask);
      stim_row_type row;
      row.ch = c;
      row.last = last;
      row.typed = typed;
      row.verdict = verdict(ok, num, mask);
      directed_rows.push_back(row);
   endtask

   task automatic add_blanks(input int lo, input int hi);
      int n;
      logic [7:0] blanks [5];
      blanks = '{CH_SPACE, CH_FF, CH_CR, CH_TAB, CH_VT};
      n = $urandom_range(lo, hi);
      repeat (n) line_text.push_back(blanks[$urandom_range(0, 4)]);
   endtask

   task automatic add_digits(input longint unsigned v);
      logic [7:0] rev [$];
      do begin
         rev.push_back(lmp_pkg::CH_ZERO + 8'(v % 10));
         v = v / 10;
      end while (v != 0);
      if ($urandom_range(0, 7) == 0) line_text.push_back(lmp_pkg::CH_ZERO);
      while (rev.size() != 0) line_text.push_back(rev.pop_back());
   endtask

   task automatic build_line();
      int kind, n, k;
      longint unsigned num;
      logic [7:0] b;
      int unsigned odd_flags [5];
      odd_flags = '{0, 33, 40, 99, 100};
      line_text.delete();
      kind = $urandom_range(0, 99);
      if (kind < 15) begin
         n = $urandom_range(1, 8);
         repeat (n) line_text.push_back(8'($urandom_range(0, 255)));
      end else begin
         add_blanks(0, 1);
         line_text.push_back(lmp_pkg::CH_HASH);
         add_blanks(0, 2);
         case ($urandom_range(0, 9))
            0: num = 0;
            1: num = LINE_MAX;
            2: num = LINE_MAX + 1 + $urandom_range(0, 5);
            3: num = {$urandom, $urandom};
            4, 5: num = $urandom;
            default: num = $urandom_range(1, 999);
         endcase
         add_digits(num);
         add_blanks(1, 2);
         line_text.push_back(lmp_pkg::CH_QUOTE);
         n = $urandom_range(0, 6);
         repeat (n) begin
            b = 8'($urandom_range(0, 255));
            if (b == lmp_pkg::CH_NL) b = lmp_pkg::CH_HASH;
            if (b == lmp_pkg::CH_QUOTE || b == lmp_pkg::CH_BSLASH || $urandom_range(0, 9) == 0)
               line_text.push_back(lmp_pkg::CH_BSLASH);
            line_text.push_back(b);
         end
         line_text.push_back(lmp_pkg::CH_QUOTE);
         n = $urandom_range(0, 4);
         for (int i = 0; i < n; i++) begin
            if (i > 0 || $urandom_range(0, 1) == 0) add_blanks(1, 2);
            if ($urandom_range(0, 9) == 0) add_digits(odd_flags[$urandom_range(0, 4)]);
            else add_digits($urandom_range(1, lmp_pkg::FLAG_BITS_DEF));
         end
         add_blanks(0, 2);
         if (kind >= 80) begin
            if ($urandom_range(0, 1) == 0) begin
               line_text[$urandom_range(0, line_text.size() - 1)] = 8'($urandom_range(0, 255));
            end else begin
               k = $urandom_range(1, line_text.size() - 1);
               while (line_text.size() > k) void'(line_text.pop_back());
            end
         end
      end
      end_on_last = $urandom_range(0, 2) == 0;
      if (!end_on_last || $urandom_range(0, 3) == 0) line_text.push_back(lmp_pkg::CH_NL);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_cycles <= 0;
      end else if (hold_cycles != 0) begin
         rsp_stall <= 1'b1;
         hold_cycles <= hold_cycles - 1;
      end else if (hold_go && !hold_done) begin
         rsp_stall <= 1'b1;
         hold_cycles <= 300;
         hold_done <= 1'b1;
      end else begin
         rsp_stall <= !calm && ($urandom_range(0, 99) < 18);
      end
   end

   task automatic compare_field(input string field, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, actual %0h", field, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      lmp_pkg::result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            $error("unexpected result transfer");
            failures++;
         end else begin
            want = expected_results.pop_front();
            compare_field("is_verdict", 32'(want.is_verdict), 32'(rsp_is_verdict));
            compare_field("name_byte", 32'(want.name_byte), 32'(rsp_name_byte));
            compare_field("ok", 32'(want.ok), 32'(rsp_ok));
            compare_field("line_number", want.line_number, rsp_line_number);
            compare_field("flag_mask", want.flag_mask, rsp_flag_mask);
            compare_field("run_end", 32'(want.run_end), 32'(rsp_run_end));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("linemarker_line_parser_top_test: FAIL");
         $finish;
      end
   end

   initial begin
      int sent;
      sent = 0;
      add_row(lmp_pkg::CH_NL, 1'b0, 1'b1, 1'b0, 32'd0, 32'd0);
      // name with 0xFF and an escaped quote, flag right after the closing quote
      add_row(lmp_pkg::CH_HASH, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0);
      add_row(lmp_pkg::CH_ZERO, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0);
      add_row(CH_SPACE, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0);
      add_row(lmp_pkg::CH_QUOTE, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0);
      add_row(8'hFF, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0);
      add_row(lmp_pkg::CH_BSLASH, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0);
      add_row(lmp_pkg::CH_QUOTE, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0);
      add_row(lmp_pkg::CH_QUOTE, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0);
      add_row("3", 1'b0, 1'b0, 1'b0, 32'd0, 32'd0);
      add_row("2", 1'b1, 1'b1, 1'b1, 32'd0, 32'h8000_0000);
      add_row("x", 1'b0, 1'b0, 1'b0, 32'd0, 32'd0);
      add_row(lmp_pkg::CH_NL, 1'b0, 1'b1, 1'b0, 32'd0, 32'd0);
      // name byte on the last byte
      add_row(lmp_pkg::CH_HASH, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0);
      add_row("5", 1'b0, 1'b0, 1'b0, 32'd0, 32'd0);
      add_row(CH_TAB, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0);
      add_row(lmp_pkg::CH_QUOTE, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0);
      add_row("z", 1'b1, 1'b0, 1'b0, 32'd0, 32'd0);
      // number not followed by whitespace
      add_row(lmp_pkg::CH_HASH, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0);
      add_row("1", 1'b0, 1'b0, 1'b0, 32'd0, 32'd0);
      add_row(lmp_pkg::CH_QUOTE, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0);
      add_row(lmp_pkg::CH_NL, 1'b0, 1'b1, 1'b0, 32'd0, 32'd0);
      add_row(8'h00, 1'b1, 1'b1, 1'b0, 32'd0, 32'd0);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         send_byte(directed_rows[i].ch, directed_rows[i].last);
         if (directed_rows[i].typed) begin
            void'(expected_results.pop_back());
            expected_results.push_back(directed_rows[i].verdict);
         end
      end

      while (sent < RANDOM_BYTES) begin
         build_line();
         foreach (line_text[i]) begin
            calm <= sent >= 700 && sent < 1000;
            hold_go <= sent >= 300;
            send_byte(line_text[i], end_on_last && i == line_text.size() - 1);
            sent++;
         end
      end
      req_valid <= 1'b0;

      while (expected_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (failures == 0) begin
         $display("linemarker_line_parser_top_test: PASS");
      end else begin
         $display("linemarker_line_parser_top_test: FAIL");
      end
      $finish;
   end

endmodule
